### design/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types, constants and helper functions of the Clarke/Park transform:
// beat structs, quarter-wave sine table, table lookup and saturation.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // field widths
  localparam int SampleBits  = 16;
  localparam int AngleBits   = 16;
  localparam int IndexBits   = 8;
  localparam int FracBits    = AngleBits - IndexBits;
  localparam int RomFrac     = 15;
  localparam int TableEntries = 1 << IndexBits;
  localparam int QuarterEntries = TableEntries / 4;

  // width used for saturation of any intermediate
  localparam int SatW = 36;

  // 1/sqrt(3) with 16 fraction bits
  localparam logic [16:0] InvSqrt3Q16 = 17'd37837;

  localparam logic signed [SatW-1:0] SatHi = 36'sd32767;
  localparam logic signed [SatW-1:0] SatLo = -36'sd32768;

  // input beat
  typedef struct packed {
    logic signed [SampleBits-1:0] phase_a_current;
    logic signed [SampleBits-1:0] phase_b_current;
    logic        [AngleBits-1:0]  electrical_angle;
  } in_t;

  // result beat
  typedef struct packed {
    logic signed [SampleBits-1:0] alpha_current;
    logic signed [SampleBits-1:0] beta_current;
    logic signed [SampleBits-1:0] sine_value;
    logic signed [SampleBits-1:0] cosine_value;
    logic signed [SampleBits-1:0] direct_current;
    logic signed [SampleBits-1:0] quadrature_current;
  } out_t;

  // quarter sine wave, 15 fraction bits, entry 64 is +1.0
  localparam logic [15:0] QuarterRom [0:64] = '{
    16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
    16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
    16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
    16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
    16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
    16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
    16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32768
  };

  // full-wave lookup by quadrant mirror and negation
  function automatic logic signed [16:0] rom_read(logic [IndexBits-1:0] idx);
    logic [IndexBits-3:0] r;
    logic [IndexBits-2:0] rr;
    logic signed [16:0]   v;
    r  = idx[IndexBits-3:0];
    rr = idx[IndexBits-2] ? (7'(QuarterEntries) - {1'b0, r}) : {1'b0, r};
    v  = $signed({1'b0, QuarterRom[rr]});
    return idx[IndexBits-1] ? -v : v;
  endfunction

  // clamp to the signed sample range
  function automatic logic signed [SampleBits-1:0] sat16(logic signed [SatW-1:0] v);
    logic signed [SampleBits-1:0] r;
    if (v > SatHi) begin
      r = 16'sh7fff;
    end else if (v < SatLo) begin
      r = 16'sh8000;
    end else begin
      r = v[SampleBits-1:0];
    end
    return r;
  endfunction

endpackage

### design/cpt_sincos.sv
// ----------------------------------------------------------------------------
// cpt_sincos
// Three-stage interpolated sine/cosine: table lookup, slope multiply,
// round and saturate.
// ----------------------------------------------------------------------------
module cpt_sincos (
  input  logic                                  clk_i,
  input  logic [cpt_pkg::AngleBits-1:0]         angle_i,
  output logic signed [cpt_pkg::SampleBits-1:0] sine_o,
  output logic signed [cpt_pkg::SampleBits-1:0] cosine_o
);

  logic [cpt_pkg::IndexBits-1:0] idx_s, idx_c;

  logic signed [16:0] y0s_q, y1s_q, y0c_q, y1c_q;
  logic [cpt_pkg::FracBits-1:0] frac_q;

  logic signed [17:0] ds, dc;
  logic signed [26:0] prod_s_d, prod_c_d;
  logic signed [26:0] prod_s_q, prod_c_q;
  logic signed [16:0] y0s2_q, y0c2_q;

  logic signed [cpt_pkg::SampleBits-1:0] sine_d, cosine_d, sine_q, cosine_q;

  // stage 1: table reads for both neighbors, cosine a quarter turn ahead
  assign idx_s = angle_i[cpt_pkg::AngleBits-1:cpt_pkg::FracBits];
  assign idx_c = idx_s + cpt_pkg::IndexBits'(cpt_pkg::QuarterEntries);

  always_ff @(posedge clk_i) begin
    y0s_q  <= cpt_pkg::rom_read(idx_s);
    y1s_q  <= cpt_pkg::rom_read(idx_s + 8'd1);
    y0c_q  <= cpt_pkg::rom_read(idx_c);
    y1c_q  <= cpt_pkg::rom_read(idx_c + 8'd1);
    frac_q <= angle_i[cpt_pkg::FracBits-1:0];
  end

  // stage 2: slope times fraction
  assign ds       = 18'(y1s_q) - 18'(y0s_q);
  assign dc       = 18'(y1c_q) - 18'(y0c_q);
  assign prod_s_d = ds * $signed({1'b0, frac_q});
  assign prod_c_d = dc * $signed({1'b0, frac_q});

  always_ff @(posedge clk_i) begin
    prod_s_q <= prod_s_d;
    prod_c_q <= prod_c_d;
    y0s2_q   <= y0s_q;
    y0c2_q   <= y0c_q;
  end

  // stage 3: round the step, add base, clamp
  assign sine_d = cpt_pkg::sat16(36'(y0s2_q) +
                  36'((prod_s_q + 27'sd128) >>> cpt_pkg::FracBits));
  assign cosine_d = cpt_pkg::sat16(36'(y0c2_q) +
                    36'((prod_c_q + 27'sd128) >>> cpt_pkg::FracBits));

  always_ff @(posedge clk_i) begin
    sine_q   <= sine_d;
    cosine_q <= cosine_d;
  end

  assign sine_o   = sine_q;
  assign cosine_o = cosine_q;

endmodule

### design/cpt_clarke.sv
// ----------------------------------------------------------------------------
// cpt_clarke
// Three-stage Clarke transform: alpha = ia, beta = (ia + 2*ib)/sqrt(3),
// rounded and saturated.
// ----------------------------------------------------------------------------
module cpt_clarke (
  input  logic                                  clk_i,
  input  logic signed [cpt_pkg::SampleBits-1:0] phase_a_i,
  input  logic signed [cpt_pkg::SampleBits-1:0] phase_b_i,
  output logic signed [cpt_pkg::SampleBits-1:0] alpha_o,
  output logic signed [cpt_pkg::SampleBits-1:0] beta_o
);

  logic signed [17:0] sum_d, sum_q;
  logic signed [cpt_pkg::SampleBits-1:0] ia1_q, ia2_q, alpha_q, beta_q;
  logic signed [34:0] prod_d, prod_q;
  logic signed [cpt_pkg::SampleBits-1:0] beta_d;

  // stage 1: ia + 2*ib
  assign sum_d = 18'(phase_a_i) + (18'(phase_b_i) <<< 1);

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    ia1_q <= phase_a_i;
  end

  // stage 2: scale by 1/sqrt(3)
  assign prod_d = sum_q * $signed(cpt_pkg::InvSqrt3Q16);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    ia2_q  <= ia1_q;
  end

  // stage 3: round to nearest and clamp
  assign beta_d = cpt_pkg::sat16(36'((prod_q + 35'sd32768) >>> 16));

  always_ff @(posedge clk_i) begin
    beta_q  <= beta_d;
    alpha_q <= ia2_q;
  end

  assign alpha_o = alpha_q;
  assign beta_o  = beta_q;

endmodule

### design/cpt_park.sv
// ----------------------------------------------------------------------------
// cpt_park
// Two-stage Park rotation: four products, then sums, rounding, saturation
// and the registered result beat.
// ----------------------------------------------------------------------------
module cpt_park (
  input  logic                                  clk_i,
  input  logic signed [cpt_pkg::SampleBits-1:0] alpha_i,
  input  logic signed [cpt_pkg::SampleBits-1:0] beta_i,
  input  logic signed [cpt_pkg::SampleBits-1:0] sine_i,
  input  logic signed [cpt_pkg::SampleBits-1:0] cosine_i,
  output cpt_pkg::out_t                         result_o
);

  logic signed [31:0] pac_q, pbs_q, pbc_q, pas_q;
  logic signed [cpt_pkg::SampleBits-1:0] alpha_q, beta_q, sine_q, cosine_q;
  logic signed [32:0] d_sum, q_sum;
  cpt_pkg::out_t result_d, result_q;

  // stage 4: products
  always_ff @(posedge clk_i) begin
    pac_q    <= alpha_i * cosine_i;
    pbs_q    <= beta_i * sine_i;
    pbc_q    <= beta_i * cosine_i;
    pas_q    <= alpha_i * sine_i;
    alpha_q  <= alpha_i;
    beta_q   <= beta_i;
    sine_q   <= sine_i;
    cosine_q <= cosine_i;
  end

  // stage 5: sums with rounding half
  assign d_sum = 33'(pac_q) + 33'(pbs_q) + 33'sd16384;
  assign q_sum = 33'(pbc_q) - 33'(pas_q) + 33'sd16384;

  always_comb begin
    result_d.alpha_current      = alpha_q;
    result_d.beta_current       = beta_q;
    result_d.sine_value         = sine_q;
    result_d.cosine_value       = cosine_q;
    result_d.direct_current     = cpt_pkg::sat16(36'(d_sum >>> cpt_pkg::RomFrac));
    result_d.quadrature_current = cpt_pkg::sat16(36'(q_sum >>> cpt_pkg::RomFrac));
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

### design/clarke_park_transform.sv
// ----------------------------------------------------------------------------
// clarke_park_transform
// Clarke and Park transform of two phase currents at a rotor angle, with an
// interpolated sine table, in a five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   A sample beat (two phase currents and an electrical angle) is taken at
//   each rising edge where start_i is high and busy_o is low. busy_o stays
//   low, so a new beat may enter on every cycle: throughput is one beat per
//   clock.
//   The result beat appears on result_o with done_o high for exactly one
//   cycle, once it has passed the stages table read, slope and 1/sqrt(3)
//   multiply, round/clamp, Park products and Park sums. The
//   receiver has no back-pressure and must take every result beat.
//   Results come out in input order, one per input beat.
//   Reset clears the valid bits of every stage; beats in flight are dropped
//   and no result strobe is given for them. The data registers have no reset.
// ----------------------------------------------------------------------------
module clarke_park_transform (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  cpt_pkg::in_t  in_i,
  output logic          done_o,
  output cpt_pkg::out_t result_o
);

  localparam int Depth = 5;

  logic [Depth-1:0] valid_d, valid_q;
  logic accept;

  logic signed [cpt_pkg::SampleBits-1:0] alpha, beta, sine, cosine;

  // no back-pressure anywhere in the pipe
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // valid bits follow the data
  assign valid_d = {valid_q[Depth-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign done_o = valid_q[Depth-1];

  // angle to sine/cosine
  cpt_sincos u_sincos (
    .clk_i    (clk_i),
    .angle_i  (in_i.electrical_angle),
    .sine_o   (sine),
    .cosine_o (cosine)
  );

  // phase currents to alpha/beta
  cpt_clarke u_clarke (
    .clk_i     (clk_i),
    .phase_a_i (in_i.phase_a_current),
    .phase_b_i (in_i.phase_b_current),
    .alpha_o   (alpha),
    .beta_o    (beta)
  );

  // rotation and result register
  cpt_park u_park (
    .clk_i    (clk_i),
    .alpha_i  (alpha),
    .beta_i   (beta),
    .sine_i   (sine),
    .cosine_i (cosine),
    .result_o (result_o)
  );

endmodule

### design/cpt_checker.sv
// ----------------------------------------------------------------------------
// cpt_checker
// Port-level checks of the transform: latency, ordering of strobes and
// known values at angle zero.
// ----------------------------------------------------------------------------
module cpt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input cpt_pkg::in_t  in_i,
  input logic          done_o,
  input cpt_pkg::out_t result_o
);

  // every taken beat gives a result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 done_o)
    else $error("result strobe missing after accepted beat");

  // no result strobe without a matching taken beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 5))
    else $error("result strobe without matching input beat");

  // alpha passes phase A through unchanged
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.alpha_current == $past(in_i.phase_a_current, 5)))
    else $error("alpha does not match phase A current");

  // at angle zero sine is zero and cosine clamps at full scale
  a_angle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(in_i.electrical_angle, 5) == 16'h0000)) |->
      (result_o.sine_value == 16'sh0000) && (result_o.cosine_value == 16'sh7fff))
    else $error("wrong sine or cosine at angle zero");

endmodule

bind clarke_park_transform cpt_checker u_cpt_checker (.*);

### verif/clarke_park_transform_tb.sv
// ----------------------------------------------------------------------------
// clarke_park_transform_tb
// Self-checking bench for the Clarke/Park transform. A queue of sample beats
// (directed corners, then random beats in several sender-idle phases) feeds a
// clocked driver; a clocked monitor predicts every accepted beat in fixed
// point and compares each result field in order of arrival.
// ----------------------------------------------------------------------------
module clarke_park_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    Latency      = 5;
  localparam int    StallLimit   = 5000;
  localparam int    PhaseBeats   = 185;
  localparam longint InvSqrt3    = 37837;

  // quarter sine wave with 15 fraction bits, last entry is +1.0
  localparam int SineQuarter [0:64] = '{
        0,   804,  1608,  2411,  3212,  4011,  4808,  5602,
     6393,  7180,  7962,  8740,  9512, 10279, 11039, 11793,
    12540, 13279, 14010, 14733, 15447, 16151, 16846, 17531,
    18205, 18868, 19520, 20160, 20788, 21403, 22006, 22595,
    23170, 23732, 24279, 24812, 25330, 25833, 26320, 26791,
    27246, 27684, 28106, 28511, 28899, 29269, 29622, 29957,
    30274, 30572, 30853, 31114, 31357, 31581, 31786, 31972,
    32138, 32286, 32413, 32522, 32610, 32679, 32729, 32758,
    32768
  };

  typedef struct {
    cpt_pkg::in_t beat;
    int unsigned  idle_pct;
    bit           drain_first;
  } sample_req_t;

  logic          clk_i;
  logic          rst_ni  = 1'b0;
  logic          start_i = 1'b0;
  logic          busy_o;
  cpt_pkg::in_t  in_i    = '0;
  logic          done_o;
  cpt_pkg::out_t result_o;

  sample_req_t   sample_queue[$];
  cpt_pkg::out_t expected_results[$];
  int unsigned beats_sent   = 0;
  int unsigned beats_seen   = 0;
  int unsigned total_beats  = 0;
  int unsigned errors       = 0;
  int unsigned idle_cycles  = 0;
  int unsigned sat_results  = 0;

  clarke_park_transform dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .in_i     (in_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------------------

  // add half, then floor
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] clamp_sample(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // full-wave table entry by quadrant mirror and negation
  function automatic longint sine_entry(int unsigned idx);
    int unsigned i;
    int unsigned quad;
    int unsigned r;
    longint      v;
    i    = idx & 255;
    quad = i / 64;
    r    = i % 64;
    if (quad & 1) r = 64 - r;
    v = SineQuarter[r];
    return (quad & 2) ? -v : v;
  endfunction

  // linear interpolation toward the next entry, which wraps after the last
  function automatic logic signed [15:0] sine_interp(int unsigned idx, int unsigned frac);
    longint y0;
    longint y1;
    y0 = sine_entry(idx);
    y1 = sine_entry(idx + 1);
    return clamp_sample(y0 + round_shift((y1 - y0) * longint'(frac), 16));
  endfunction

  function automatic cpt_pkg::out_t transform_beat(cpt_pkg::in_t beat);
    cpt_pkg::out_t r;
    longint      ia;
    longint      ib;
    longint      beta;
    longint      s;
    longint      c;
    int unsigned idx;
    int unsigned frac;
    ia   = beat.phase_a_current;
    ib   = beat.phase_b_current;
    idx  = beat.electrical_angle[15:8];
    frac = {beat.electrical_angle[7:0], 8'h00};
    r.alpha_current = beat.phase_a_current;
    r.beta_current  = clamp_sample(round_shift((ia + 2 * ib) * InvSqrt3, 16));
    r.sine_value    = sine_interp(idx, frac);
    r.cosine_value  = sine_interp(idx + 64, frac);
    beta = r.beta_current;
    s    = r.sine_value;
    c    = r.cosine_value;
    r.direct_current     = clamp_sample(round_shift(ia * c + beta * s, 15));
    r.quadrature_current = clamp_sample(round_shift(beta * c - ia * s, 15));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_sample(logic signed [15:0] ia, logic signed [15:0] ib,
                              logic [15:0] angle, int unsigned idle_pct, bit drain);
    sample_req_t req;
    req.beat.phase_a_current  = ia;
    req.beat.phase_b_current  = ib;
    req.beat.electrical_angle = angle;
    req.idle_pct              = idle_pct;
    req.drain_first           = drain;
    sample_queue.push_back(req);
    total_beats++;
  endtask

  // random current, weighted toward full scale and near zero
  function automatic logic signed [15:0] rand_current();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(32)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  // random angle, weighted toward table boundaries, interval midpoints and the wrap region
  function automatic logic [15:0] rand_angle();
    case ($urandom_range(7))
      0: return {8'($urandom_range(255)), 8'h00};
      1: return {8'hff, 8'($urandom_range(255))};
      2: return {8'($urandom_range(255)), 8'h80};
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued beats, idles at random, drains on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i    <= 1'b0;
      in_i       <= '0;
      beats_sent <= 0;
    end else begin
      if (start_i && !busy_o) begin
        beats_sent <= beats_sent + 1;
      end
      if (!start_i || !busy_o) begin
        if (sample_queue.size() == 0) begin
          start_i <= 1'b0;
        end else if (sample_queue[0].drain_first &&
                     beats_seen != beats_sent + ((start_i && !busy_o) ? 1 : 0)) begin
          start_i <= 1'b0;
        end else if ($urandom_range(99) < sample_queue[0].idle_pct) begin
          start_i <= 1'b0;
        end else begin
          in_i    <= sample_queue[0].beat;
          start_i <= 1'b1;
          sample_queue.pop_front();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks result beats, then predicts the beat accepted at this edge
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic signed [15:0] exp_v,
                             logic signed [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    cpt_pkg::out_t exp_r;
    if (rst_ni) begin
      if (done_o) begin
        beats_seen <= beats_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $realtime, result_o);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("alpha", exp_r.alpha_current, result_o.alpha_current);
          check_field("beta", exp_r.beta_current, result_o.beta_current);
          check_field("sine", exp_r.sine_value, result_o.sine_value);
          check_field("cosine", exp_r.cosine_value, result_o.cosine_value);
          check_field("d", exp_r.direct_current, result_o.direct_current);
          check_field("q", exp_r.quadrature_current, result_o.quadrature_current);
        end
      end
      if (start_i && !busy_o) begin
        exp_r = transform_beat(in_i);
        if (exp_r.beta_current == 16'sh7fff || exp_r.beta_current == 16'sh8000 ||
            exp_r.direct_current == 16'sh7fff || exp_r.direct_current == 16'sh8000 ||
            exp_r.quadrature_current == 16'sh7fff ||
            exp_r.quadrature_current == 16'sh8000) begin
          sat_results++;
        end
        expected_results.push_back(exp_r);
      end
    end
  end

  // watchdog on cycles with no beat moving either way
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no beat moved for %0d cycles", $realtime, StallLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: fill the queue, release reset, wait for every result
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_idle [4];
    phase_idle = '{0, 56, 9, 0};

    // directed corners: full scale, zero, quadrant points, table wrap
    queue_sample(16'sh0000, 16'sh0000, 16'h0000, 0, 1'b0);
    queue_sample(16'sh7fff, 16'sh7fff, 16'h0000, 0, 1'b0);
    queue_sample(16'sh8000, 16'sh8000, 16'h0000, 0, 1'b0);
    queue_sample(16'sh7fff, 16'sh8000, 16'h4000, 0, 1'b0);
    queue_sample(16'sh8000, 16'sh7fff, 16'h8000, 0, 1'b0);
    queue_sample(16'sh4000, 16'sh2000, 16'hc000, 0, 1'b0);
    queue_sample(16'sh7fff, 16'sh7fff, 16'h2000, 0, 1'b0);
    queue_sample(16'sh8000, 16'sh8000, 16'h2000, 0, 1'b0);
    queue_sample(16'sh7fff, 16'sh7fff, 16'ha000, 0, 1'b0);
    queue_sample(16'sh8000, 16'sh7fff, 16'he000, 0, 1'b0);
    queue_sample(16'sh1234, 16'shedcb, 16'hffff, 0, 1'b0);
    queue_sample(16'sh7fff, 16'sh0000, 16'hff80, 0, 1'b0);
    queue_sample(16'sh8000, 16'sh0000, 16'h00ff, 0, 1'b0);
    queue_sample(16'sh0001, 16'shffff, 16'h3f80, 0, 1'b0);
    queue_sample(16'shffff, 16'sh0001, 16'h4080, 0, 1'b0);
    queue_sample(16'sh5555, 16'shaaaa, 16'h5555, 0, 1'b0);
    queue_sample(16'shaaaa, 16'sh5555, 16'haaaa, 0, 1'b0);
    queue_sample(16'sh0000, 16'sh7fff, 16'h7fff, 0, 1'b0);
    queue_sample(16'sh0000, 16'sh8000, 16'h8001, 0, 1'b0);
    queue_sample(16'sh2000, 16'sh2000, 16'h0100, 0, 1'b0);

    // random phases, each opened by a full drain of the pipeline
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < PhaseBeats; i++) begin
        queue_sample(rand_current(), rand_current(), rand_angle(), phase_idle[p],
                     (i == 0) || (p == 1 && i == PhaseBeats / 2));
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (beats_seen < total_beats) @(posedge clk_i);
    repeat (Latency * 2) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime,
               expected_results.size());
      errors++;
    end

    $display("%0d sample beats sent, %0d results checked in four idle phases",
             total_beats, beats_seen);
    $display("%0d results hit a clamp; %0d mismatches", sat_results, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
